// ===== hw/rtl/tmsch_pkg.sv =====
// Shared types and constants of the multi-timer event scheduler.
`default_nettype none
package tmsch_pkg;

    localparam int unsigned REG_W  = 32;
    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_SYSTICK_PERIOD = 3'd0;
    localparam logic [2:0] REG_T1_MATCH       = 3'd1;
    localparam logic [2:0] REG_T1_PRESCALE    = 3'd2;
    localparam logic [2:0] REG_T2_MATCH       = 3'd3;
    localparam logic [2:0] REG_T2_PRESCALE    = 3'd4;
    localparam logic [2:0] REG_T1_IRQ_ENABLE  = 3'd5;
    localparam logic [2:0] REG_T2_IRQ_ENABLE  = 3'd6;

    localparam logic [REG_W-1:0] SYSTICK_PERIOD_RESET = 32'd25000;

    // Settings seen by the timer datapath; match limits are precomputed.
    typedef struct packed {
        logic [REG_W-1:0] systick_period;
        logic [REG_W-1:0] t1_limit;
        logic             t1_limit_over;
        logic [REG_W-1:0] t2_limit;
        logic             t2_limit_over;
        logic             t1_irq_enable;
        logic             t2_irq_enable;
    } t_tmsch_cfg;

endpackage
`default_nettype wire

// ===== hw/rtl/multi_timer_event_scheduler_unit.sv =====
// Top level of the multi-timer event scheduler: base counter, system tick, output register.
`default_nettype none
// Each input word is one base tick (bit 0 advance) or a plain sample, with the processor
// interrupt enable in bit 1. The block answers every word with exactly one result word and
// takes one word per clock while not held off: the master count, the system tick compare
// and both match timer compares settle combinationally between the state registers and the
// output register, and a new word is accepted while the previous result waits, as long as
// the output register is free or being emptied in the same cycle. After every APB write the
// input is held off while the match limits match*(prescale+1) are recomputed through one
// registered 32x32 multiplier and one adder per timer; the multiply and add never appear on
// the critical path of a tick.
// The system tick keeps its phase: on firing its last-fire time moves by one period, so a
// lowered period fires once per word until it has caught up. Registers sit at byte address
// 4*index; there is no clearing pass after reset.
module multi_timer_event_scheduler_unit
    import tmsch_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input word: [0] advance, [1] global_irq_enable, [7:2] zero.
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,
    // Result word: [0] systick_event, [1] t1_matched, [2] t1_irq, [3] t2_matched,
    // [4] t2_irq, [36:5] master_time, [39:37] zero.
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [39:0]            m_axis_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_tmsch_cfg       cfg;
    logic             cfg_busy;
    logic             in_accept;
    logic             adv;
    logic             gie;
    logic [REG_W-1:0] r_master;
    logic [REG_W-1:0] r_systick_last;
    logic [REG_W-1:0] n_master;
    logic             sys_hit;
    logic             t1_hit;
    logic             t2_hit;
    logic             r_out_valid;
    logic [39:0]      r_out_data;

    tmsch_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_busy  (cfg_busy)
    );

    // The output register is free when empty or drained in this same cycle.
    assign s_axis_tready = !cfg_busy && (!r_out_valid || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign adv           = s_axis_tdata[0];
    assign gie           = s_axis_tdata[1];

    // All compares look at the count after this word's advance.
    assign n_master = r_master + {{(REG_W-1){1'b0}}, adv};
    assign sys_hit  = (n_master - r_systick_last) >= cfg.systick_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master       <= '0;
            r_systick_last <= '0;
        end else if (in_accept) begin
            r_master <= n_master;
            if (sys_hit) begin
                r_systick_last <= r_systick_last + cfg.systick_period;
            end
        end
    end

    tmsch_match u_t1 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_now        (n_master),
        .i_limit      (cfg.t1_limit),
        .i_limit_over (cfg.t1_limit_over),
        .o_matched    (t1_hit)
    );

    tmsch_match u_t2 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_now        (n_master),
        .i_limit      (cfg.t2_limit),
        .i_limit_over (cfg.t2_limit_over),
        .o_matched    (t2_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= {3'd0, n_master,
                           t2_hit && cfg.t2_irq_enable && gie, t2_hit,
                           t1_hit && cfg.t1_irq_enable && gie, t1_hit,
                           sys_hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // No word may enter while the match limits are being recomputed.
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_busy |-> !s_axis_tready)
        else $error("input accepted during limit recompute");

    // An accepted advance moves the reported time forward by exactly one.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && adv) |=> (m_axis_tdata[36:5] == $past(r_master) + 32'd1))
        else $error("master time did not advance by one");

    // Every accepted word leaves a result waiting on the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted word produced no result");

    // An interrupt is only ever raised together with its match.
    a_irq_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((!m_axis_tdata[2] || m_axis_tdata[1])
                           && (!m_axis_tdata[4] || m_axis_tdata[3])))
        else $error("interrupt without match");

endmodule
`default_nettype wire

// ===== hw/rtl/tmsch_cfg.sv =====
// Register file of the scheduler with match limit precompute.
`default_nettype none
module tmsch_cfg
    import tmsch_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output t_tmsch_cfg             o_cfg,
    output logic                   o_busy
);

    logic [REG_W-1:0]   r_systick_period;
    logic [REG_W-1:0]   r_t1_match;
    logic [REG_W-1:0]   r_t1_prescale;
    logic [REG_W-1:0]   r_t2_match;
    logic [REG_W-1:0]   r_t2_prescale;
    logic               r_t1_irq_enable;
    logic               r_t2_irq_enable;
    logic [2*REG_W-1:0] r_t1_prod;
    logic [2*REG_W-1:0] r_t2_prod;
    logic [REG_W-1:0]   r_t1_limit;
    logic [REG_W-1:0]   r_t2_limit;
    logic               r_t1_over;
    logic               r_t2_over;
    logic [1:0]         r_busy_cnt;
    logic [2*REG_W-1:0] n_t1_sum;
    logic [2*REG_W-1:0] n_t2_sum;
    logic               wr_en;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_systick_period <= SYSTICK_PERIOD_RESET;
            r_t1_match       <= '0;
            r_t1_prescale    <= '0;
            r_t2_match       <= '0;
            r_t2_prescale    <= '0;
            r_t1_irq_enable  <= 1'b0;
            r_t2_irq_enable  <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SYSTICK_PERIOD: r_systick_period <= pwdata;
                REG_T1_MATCH:       r_t1_match       <= pwdata;
                REG_T1_PRESCALE:    r_t1_prescale    <= pwdata;
                REG_T2_MATCH:       r_t2_match       <= pwdata;
                REG_T2_PRESCALE:    r_t2_prescale    <= pwdata;
                REG_T1_IRQ_ENABLE:  r_t1_irq_enable  <= pwdata[0];
                REG_T2_IRQ_ENABLE:  r_t2_irq_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // match*(prescale+1) is formed as match*prescale + match: product register, then limit register.
    assign n_t1_sum = r_t1_prod + {{REG_W{1'b0}}, r_t1_match};
    assign n_t2_sum = r_t2_prod + {{REG_W{1'b0}}, r_t2_match};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_prod <= '0;
            r_t2_prod <= '0;
        end else begin
            r_t1_prod <= {{REG_W{1'b0}}, r_t1_match} * {{REG_W{1'b0}}, r_t1_prescale};
            r_t2_prod <= {{REG_W{1'b0}}, r_t2_match} * {{REG_W{1'b0}}, r_t2_prescale};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_limit <= '0;
            r_t2_limit <= '0;
            r_t1_over  <= 1'b0;
            r_t2_over  <= 1'b0;
            r_busy_cnt <= 2'd0;
        end else begin
            r_t1_limit <= n_t1_sum[REG_W-1:0];
            r_t2_limit <= n_t2_sum[REG_W-1:0];
            r_t1_over  <= |n_t1_sum[2*REG_W-1:REG_W];
            r_t2_over  <= |n_t2_sum[2*REG_W-1:REG_W];
            if (wr_en) begin
                r_busy_cnt <= 2'd2;
            end else if (r_busy_cnt != 2'd0) begin
                r_busy_cnt <= r_busy_cnt - 2'd1;
            end
        end
    end

    assign o_busy = (r_busy_cnt != 2'd0);

    always_comb begin
        case (reg_idx)
            REG_SYSTICK_PERIOD: prdata = r_systick_period;
            REG_T1_MATCH:       prdata = r_t1_match;
            REG_T1_PRESCALE:    prdata = r_t1_prescale;
            REG_T2_MATCH:       prdata = r_t2_match;
            REG_T2_PRESCALE:    prdata = r_t2_prescale;
            REG_T1_IRQ_ENABLE:  prdata = {31'd0, r_t1_irq_enable};
            REG_T2_IRQ_ENABLE:  prdata = {31'd0, r_t2_irq_enable};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.systick_period = r_systick_period;
    assign o_cfg.t1_limit       = r_t1_limit;
    assign o_cfg.t1_limit_over  = r_t1_over;
    assign o_cfg.t2_limit       = r_t2_limit;
    assign o_cfg.t2_limit_over  = r_t2_over;
    assign o_cfg.t1_irq_enable  = r_t1_irq_enable;
    assign o_cfg.t2_irq_enable  = r_t2_irq_enable;

endmodule
`default_nettype wire

// ===== hw/rtl/tmsch_match.sv =====
// One prescaled match timer: elapsed-time compare and restart register.
`default_nettype none
module tmsch_match
    import tmsch_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [REG_W-1:0] i_now,
    input  wire logic [REG_W-1:0] i_limit,
    input  wire logic             i_limit_over,
    output logic                  o_matched
);

    logic [REG_W-1:0] r_last;
    logic [REG_W-1:0] elapsed;

    assign elapsed   = i_now - r_last;
    // A limit above 32 bits can never be reached.
    assign o_matched = !i_limit_over && (elapsed >= i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_accept && o_matched) begin
            r_last <= i_now;
        end
    end

endmodule
`default_nettype wire

// ===== test/multi_timer_event_scheduler_unit_test.sv =====
// Self-checking testbench for the multi-timer event scheduler unit.
`timescale 1ns / 100ps

// Tick words go in through a queue-fed driver. Each accepted word is run through a
// behavioral copy of the scheduler, and the predicted result word is queued. A monitor
// takes result words off the master side and compares them field by field with the
// oldest prediction. Register writes over APB happen only while the unit is idle, so the
// copy of the settings in the testbench always matches the one the unit is using.
module multi_timer_event_scheduler_unit_test;
    import tmsch_pkg::*;

    // A write to this index is outside the register map and must change nothing.
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    // Input word fields, from the lowest bit up: advance, global_irq_enable.
    typedef struct packed {
        logic global_irq_enable;
        logic advance;
    } t_tick;

    // Result word fields, from the lowest bit up, as they sit in m_axis_tdata[36:0].
    typedef struct packed {
        logic [31:0] master_time;
        logic        t2_irq;
        logic        t2_matched;
        logic        t1_irq;
        logic        t1_matched;
        logic        systick_event;
    } t_timer_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    wire               s_axis_tready;
    // Fields from the lowest bit up: advance, global_irq_enable, six zero bits.
    logic [7:0]        s_axis_tdata = '0;
    wire               m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // Fields from the lowest bit up: systick_event, t1_matched, t1_irq, t2_matched,
    // t2_irq, master_time, three zero bits.
    wire  [39:0]       m_axis_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    wire  [31:0]       prdata;
    wire               pready;

    multi_timer_event_scheduler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Settings as the unit should hold them; these start at their reset values.
    logic [31:0] systick_period_cfg = SYSTICK_PERIOD_RESET;
    logic [31:0] t1_match_cfg = '0;
    logic [31:0] t1_prescale_cfg = '0;
    logic [31:0] t2_match_cfg = '0;
    logic [31:0] t2_prescale_cfg = '0;
    logic        t1_irq_enable_cfg = 1'b0;
    logic        t2_irq_enable_cfg = 1'b0;

    // Timer state of the behavioral copy, all zero after reset.
    logic [31:0] base_count = '0;
    logic [31:0] systick_last_fire = '0;
    logic [31:0] t1_restart_time = '0;
    logic [31:0] t2_restart_time = '0;

    t_tick         pending_ticks[$];
    t_timer_result expected_results[$];
    int unsigned   mismatches = 0;
    // Set for the last phase of the run, where neither side idles.
    logic          calm = 1'b0;
    logic [4:0]    send_gap = '0;
    logic [4:0]    recv_stall = '0;

    // A match timer is due once the ticks since its restart reach match*(prescale+1).
    // The product is formed in 64 bits, so a limit beyond the 32-bit elapsed range is
    // simply never reached.
    function automatic logic match_due(input logic [31:0] match, input logic [31:0] prescale,
                                       input logic [31:0] since);
        logic [63:0] limit;
        limit = {32'd0, match} * ({32'd0, prescale} + 64'd1);
        return {32'd0, since} >= limit;
    endfunction

    // Runs one tick word through the behavioral copy and returns the result word it
    // should produce. All elapsed times are modular 32-bit differences.
    function automatic t_timer_result advance_timers(input t_tick t);
        t_timer_result r;
        logic [31:0]   since;
        base_count = base_count + {31'd0, t.advance};
        // The system tick keeps its phase: its last-fire time moves by exactly one period,
        // so a period lowered below the elapsed time fires on every word until caught up.
        since = base_count - systick_last_fire;
        r.systick_event = since >= systick_period_cfg;
        if (r.systick_event) begin
            systick_last_fire = systick_last_fire + systick_period_cfg;
        end
        r.t1_matched = match_due(t1_match_cfg, t1_prescale_cfg, base_count - t1_restart_time);
        if (r.t1_matched) begin
            t1_restart_time = base_count;
        end
        r.t2_matched = match_due(t2_match_cfg, t2_prescale_cfg, base_count - t2_restart_time);
        if (r.t2_matched) begin
            t2_restart_time = base_count;
        end
        r.t1_irq = r.t1_matched && t1_irq_enable_cfg && t.global_irq_enable;
        r.t2_irq = r.t2_matched && t2_irq_enable_cfg && t.global_irq_enable;
        r.master_time = base_count;
        return r;
    endfunction

    task automatic note_mismatch(input string why, input t_timer_result want,
                                 input t_timer_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected sys=%b t1m=%b t1i=%b t2m=%b t2i=%b time=%0d",
                     $time, why, want.systick_event, want.t1_matched, want.t1_irq,
                     want.t2_matched, want.t2_irq, want.master_time);
            $display("%0t: %s: actual   sys=%b t1m=%b t1i=%b t2m=%b t2i=%b time=%0d",
                     $time, why, got.systick_event, got.t1_matched, got.t1_irq,
                     got.t2_matched, got.t2_irq, got.master_time);
        end
    endtask

    // Driver: holds a word until it is taken, then either pauses for a burst of idle
    // cycles or presents the next pending word. The prediction is made at the edge that
    // accepts the word, which is the order in which the unit sees the words too.
    always @(posedge i_clk) begin : tick_driver
        logic accepted;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= '0;
        end else begin
            accepted = s_axis_tvalid && s_axis_tready;
            if (accepted) begin
                expected_results.push_back(advance_timers(t_tick'(s_axis_tdata[1:0])));
            end
            if (s_axis_tvalid && !accepted) begin
                // The current word stays on the bus until the unit takes it.
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 5'd1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                s_axis_tdata <= {6'd0, pending_ticks.pop_front()};
                s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap <= 5'($urandom_range(1, 17));
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks every accepted result word against the oldest prediction and
    // stalls the result side in random bursts.
    always @(posedge i_clk) begin : result_monitor
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_timer_result'(m_axis_tdata[36:0]);
                if (expected_results.size() == 0) begin
                    note_mismatch("result word with nothing expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.systick_event !== want.systick_event ||
                        got.t1_matched !== want.t1_matched || got.t1_irq !== want.t1_irq ||
                        got.t2_matched !== want.t2_matched || got.t2_irq !== want.t2_irq ||
                        got.master_time !== want.master_time) begin
                        note_mismatch("wrong result word", want, got);
                    end
                end
            end
            if (recv_stall != 0) begin
                recv_stall <= recv_stall - 5'd1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                // The stall starts in this cycle and recv_stall extends it.
                recv_stall <= 5'($urandom_range(0, 16));
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_tick(input logic advance, input logic global_irq_enable);
        t_tick t;
        t.advance = advance;
        t.global_irq_enable = global_irq_enable;
        pending_ticks.push_back(t);
    endtask

    // Idle means every queued word has been sent and every predicted result has come
    // back. Every word yields a result, so nothing can still be in flight after that.
    // Sampling at the falling edge keeps clear of the updates made at the rising edge.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_ticks.size() != 0 || s_axis_tvalid ||
                   expected_results.size() != 0);
    endtask

    // APB write: a setup cycle, then an access cycle that ends at the edge where pready
    // is seen high. The copy of the settings is updated once the write has landed.
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_SYSTICK_PERIOD: systick_period_cfg = value;
            REG_T1_MATCH:       t1_match_cfg = value;
            REG_T1_PRESCALE:    t1_prescale_cfg = value;
            REG_T2_MATCH:       t2_match_cfg = value;
            REG_T2_PRESCALE:    t2_prescale_cfg = value;
            REG_T1_IRQ_ENABLE:  t1_irq_enable_cfg = value[0];
            REG_T2_IRQ_ENABLE:  t2_irq_enable_cfg = value[0];
            default: ;
        endcase
    endtask

    // Match values are kept small most of the time, since time only advances one tick
    // per word; now and then a huge value makes the timer unreachable.
    function automatic logic [31:0] pick_match();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(0, 6));
        endcase
    endfunction

    function automatic logic [31:0] pick_prescale();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(0, 3));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned phase;
        int unsigned k;
        logic [31:0] period;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: both match values are zero, so both timers fire on every word,
        // while their interrupt enables are still off. All four input combinations.
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);

        // Enables with stray upper bits set; only bit 0 counts.
        wait_idle();
        write_register(REG_T1_IRQ_ENABLE, 32'hFFFF_FFFF);
        write_register(REG_T2_IRQ_ENABLE, 32'h0000_0003);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b0);

        // Match products beyond 32 bits can never be reached, including the case where
        // only the prescale term pushes the product over. The unmapped write must be a
        // no-op.
        wait_idle();
        write_register(REG_T1_MATCH, 32'hFFFF_FFFF);
        write_register(REG_T1_PRESCALE, 32'hFFFF_FFFF);
        write_register(REG_T2_MATCH, 32'd1);
        write_register(REG_T2_PRESCALE, 32'hFFFF_FFFF);
        write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
        for (k = 0; k < 8; k++) begin
            queue_tick(1'b1, k[0]);
        end

        // Lower the system tick period well below the elapsed time: the tick must fire
        // once per word until caught up, one period at a time, also on non-advancing words.
        wait_idle();
        write_register(REG_SYSTICK_PERIOD, 32'd3);
        for (k = 0; k < 8; k++) begin
            queue_tick(k[1], 1'b1);
        end

        // A zero period fires on every word and leaves the last-fire time in place.
        wait_idle();
        write_register(REG_SYSTICK_PERIOD, 32'd0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);

        // Random phases: fresh settings while idle, then a batch of random tick words.
        // The last phase runs with no idling on either side.
        for (phase = 0; phase < 12; phase++) begin
            wait_idle();
            if (phase == 0 || $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0:       period = 32'd0;
                    1:       period = 32'hFFFF_FFFF;
                    2:       period = $urandom;
                    default: period = 32'($urandom_range(1, 12));
                endcase
                write_register(REG_SYSTICK_PERIOD, period);
            end
            if (phase == 0 || $urandom_range(0, 1) == 0) begin
                write_register(REG_T1_MATCH, pick_match());
                write_register(REG_T1_PRESCALE, pick_prescale());
            end
            if (phase == 0 || $urandom_range(0, 1) == 0) begin
                write_register(REG_T2_MATCH, pick_match());
                write_register(REG_T2_PRESCALE, pick_prescale());
            end
            if ($urandom_range(0, 1) == 0) begin
                write_register(REG_T1_IRQ_ENABLE, $urandom);
            end
            if ($urandom_range(0, 1) == 0) begin
                write_register(REG_T2_IRQ_ENABLE, $urandom);
            end
            if ($urandom_range(0, 5) == 0) begin
                write_register(REG_UNMAPPED, $urandom);
            end
            if (phase == 11) begin
                calm = 1'b1;
            end
            for (k = 0; k < 100; k++) begin
                queue_tick($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
            end
        end

        // Drain, then give any stray extra result word a chance to show up.
        wait_idle();
        repeat (20) @(posedge i_clk);
        mismatches += expected_results.size();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: the slowest correct run takes well under a tenth of this.
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
